### src/pts_pkg.sv
// Shared types, constants and functions of the priority task scheduler.
`timescale 1ns / 1ps
package pts_pkg;

	localparam int DefaultTaskSlots = 16;
	localparam logic [7:0] IdlePriorityReset = 8'd255;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_CREATE  = 3'd1,
		CMD_SLEEP   = 3'd2,
		CMD_SETPRIO = 3'd3,
		CMD_EXIT    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_EMPTY      = 3'd0,
		ST_READY      = 3'd1,
		ST_RUNNING    = 3'd2,
		ST_SLEEPING   = 3'd3,
		ST_TERMINATED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_PREP,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_FETCH,
		FSM_READ,
		FSM_OUT
	} fsm_t;

	localparam logic [2:0] REG_IDLE_PRIORITY = 3'd0;

	function automatic logic [7:0] quantum_of(input logic [7:0] prio);
		logic [7:0] q;
		case (prio[7:5])
			3'd0: q = 8'd1;
			3'd1: q = 8'd5;
			3'd2: q = 8'd10;
			3'd3: q = 8'd20;
			3'd4: q = 8'd50;
			3'd5: q = 8'd75;
			3'd6: q = 8'd100;
			default: q = 8'd200;
		endcase
		return q;
	endfunction

endpackage

### src/pts_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module pts_ram #(
	parameter int Width = 64,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### src/priority_task_scheduler.sv
// Top level of the priority task scheduler: slot table, scan sequencer and ports.
//
//  channel  | dir | beat contents
//  s_axis   | in  | tdata: command, now, context_ptr, priority_req, duration, task_slot
//  m_axis   | out | tdata: next_context, running_slot, switched, created_slot, table_full
//  apb      | in  | idle_priority at byte address 0
//
// A tick passes PREP, SCAN, DECIDE, FETCH, READ and OUT in turn: one comparator
// walks the table one slot per cycle, then the context memory is read through its single
// port. Other commands go from PREP straight to OUT. The input is ready again once the
// sequencer is back in idle, so a new command is taken only after the last one has left
// OUT; a result beat that waits holds the next result in its last stage.
// Reset puts slot 0 running as idle task; contexts are not cleared.
`timescale 1ns / 1ps
module priority_task_scheduler #(
	parameter int TASK_SLOTS = pts_pkg::DefaultTaskSlots
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[2:0], now[66:3], context_ptr[130:67], priority_req[138:131],
	// duration[170:139], task_slot[174:171], zero fill
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// next_context[63:0], running_slot[67:64], switched[68], created_slot[72:69],
	// table_full[73], zero fill
	output logic [79:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import pts_pkg::*;

	localparam int SW = $clog2(TASK_SLOTS);
	localparam int FW = $clog2(TASK_SLOTS + 1);
	localparam logic [SW-1:0] LastSlot = SW'(TASK_SLOTS - 1);

	status_t        status_q [TASK_SLOTS];
	logic [7:0]     prio_q   [TASK_SLOTS];
	logic [7:0]     quant_q  [TASK_SLOTS];
	logic [7:0]     base_q   [TASK_SLOTS];
	logic [63:0]    wake_q   [TASK_SLOTS];
	logic [7:0]     idle_prio_q;
	logic [SW-1:0]  cur_q;
	logic [FW-1:0]  free_q;

	fsm_t state_q, state_d;

	// Latched input beat.
	logic [2:0]     cmd_q;
	logic [63:0]    now_q, ctx_q;
	logic [7:0]     preq_q;
	logic [31:0]    dur_q;
	logic [3:0]     tslot_q;

	logic [SW-1:0]  idx_q;
	logic [SW:0]    cnt_q;
	logic [SW-1:0]  best_q;
	logic           found_q;
	logic           keep_q;
	logic           sw_q;
	logic           full_q;
	logic [3:0]     created_q;
	logic [79:0]    out_q;
	logic           ovalid_q;

	// Context memory port.
	logic           ram_we;
	logic [SW-1:0]  ram_addr;
	logic [63:0]    ram_wdata, ram_rdata;

	pts_ram #(.Width(64), .Depth(TASK_SLOTS)) u_ctx_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	logic in_fire, cfg_wr, out_free;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_wr = psel && penable && pwrite && (paddr == 2'(REG_IDLE_PRIORITY));
	assign pready = 1'b1;
	assign prdata = {24'd0, idle_prio_q};
	assign s_axis_tready = (state_q == FSM_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;
	// The output register can take a new beat when empty or drained in this cycle.
	assign out_free = !ovalid_q || m_axis_tready;

	// Scan view of the slot under the pointer, with wake-up applied.
	status_t    sc_stat;
	logic       sc_wake, sc_cand, sc_better;
	assign sc_wake = (status_q[idx_q] == ST_SLEEPING) && (now_q >= wake_q[idx_q]);
	assign sc_stat = sc_wake ? ST_READY : status_q[idx_q];
	assign sc_cand = (sc_stat == ST_READY) || (sc_stat == ST_RUNNING);
	assign sc_better = !found_q || (prio_q[idx_q] < prio_q[best_q]);

	logic [SW-1:0] idx_next;
	assign idx_next = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;

	logic keep;
	assign keep = (status_q[cur_q] == ST_RUNNING) && (quant_q[cur_q] != 8'd0) &&
		(!found_q || prio_q[cur_q] <= prio_q[best_q]);

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_addr = cur_q;
		ram_wdata = ctx_q;
		unique case (state_q)
			FSM_IDLE: if (in_fire) state_d = FSM_PREP;
			FSM_PREP: begin
				if (cmd_q == 3'(CMD_TICK)) begin
					ram_we = 1'b1;
					state_d = FSM_SCAN;
				end else if (cmd_q == 3'(CMD_CREATE) && !full_q) begin
					ram_we = 1'b1;
					ram_addr = free_q[SW-1:0];
					state_d = FSM_OUT;
				end else begin
					state_d = FSM_OUT;
				end
			end
			FSM_SCAN: if (cnt_q == (SW+1)'(TASK_SLOTS - 1)) state_d = FSM_DECIDE;
			FSM_DECIDE: state_d = FSM_FETCH;
			FSM_FETCH: state_d = FSM_READ;
			FSM_READ: state_d = FSM_OUT;
			FSM_OUT: if (out_free) state_d = FSM_IDLE;
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= s_axis_tdata[2:0];
			now_q   <= s_axis_tdata[66:3];
			ctx_q   <= s_axis_tdata[130:67];
			preq_q  <= s_axis_tdata[138:131];
			dur_q   <= s_axis_tdata[170:139];
			tslot_q <= s_axis_tdata[174:171];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				status_q[i] <= ST_EMPTY;
				prio_q[i]   <= 8'd0;
				quant_q[i]  <= 8'd0;
				base_q[i]   <= 8'd0;
				wake_q[i]   <= 64'd0;
			end
			status_q[0] <= ST_RUNNING;
			prio_q[0]   <= IdlePriorityReset;
			quant_q[0]  <= quantum_of(IdlePriorityReset);
			base_q[0]   <= quantum_of(IdlePriorityReset);
			idle_prio_q <= IdlePriorityReset;
			cur_q       <= '0;
			free_q      <= FW'(1);
			idx_q       <= '0;
			cnt_q       <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			keep_q      <= 1'b0;
			sw_q        <= 1'b0;
			full_q      <= 1'b0;
			created_q   <= '0;
			ovalid_q    <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_wr) begin
				idle_prio_q <= pwdata[7:0];
				prio_q[0]   <= pwdata[7:0];
				base_q[0]   <= quantum_of(pwdata[7:0]);
			end
			if (state_q == FSM_OUT && out_free) ovalid_q <= 1'b1;
			else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				FSM_IDLE: begin
					if (in_fire) begin
						sw_q <= 1'b0;
						created_q <= '0;
						full_q <= (s_axis_tdata[2:0] == 3'(CMD_CREATE)) &&
							(free_q >= FW'(TASK_SLOTS));
					end
				end
				FSM_PREP: begin
					found_q <= 1'b0;
					cnt_q <= '0;
					idx_q <= (cur_q == LastSlot) ? '0 : cur_q + 1'b1;
					unique case (cmd_q)
						3'(CMD_TICK): begin
							if (quant_q[cur_q] != 8'd0) quant_q[cur_q] <= quant_q[cur_q] - 8'd1;
						end
						3'(CMD_CREATE): begin
							if (!full_q) begin
								status_q[free_q[SW-1:0]] <= ST_READY;
								prio_q[free_q[SW-1:0]]   <= preq_q;
								quant_q[free_q[SW-1:0]]  <= quantum_of(preq_q);
								base_q[free_q[SW-1:0]]   <= quantum_of(preq_q);
								wake_q[free_q[SW-1:0]]   <= 64'd0;
								created_q <= 4'(free_q);
								free_q <= free_q + 1'b1;
							end
						end
						3'(CMD_SLEEP): begin
							status_q[cur_q] <= ST_SLEEPING;
							wake_q[cur_q] <= now_q + {32'd0, dur_q};
						end
						3'(CMD_SETPRIO): begin
							if (int'(tslot_q) < TASK_SLOTS &&
								status_q[SW'(tslot_q)] != ST_EMPTY) begin
								prio_q[SW'(tslot_q)] <= preq_q;
								base_q[SW'(tslot_q)] <= quantum_of(preq_q);
							end
						end
						3'(CMD_EXIT): status_q[cur_q] <= ST_TERMINATED;
						default: ;
					endcase
				end
				FSM_SCAN: begin
					if (sc_wake) begin
						status_q[idx_q] <= ST_READY;
						quant_q[idx_q] <= base_q[idx_q];
					end
					if (sc_cand && sc_better) begin
						best_q <= idx_q;
						found_q <= 1'b1;
					end
					idx_q <= idx_next;
					cnt_q <= cnt_q + 1'b1;
				end
				FSM_DECIDE: begin
					keep_q <= keep;
					if (!keep && found_q && best_q != cur_q) begin
						if (status_q[cur_q] == ST_RUNNING) status_q[cur_q] <= ST_READY;
						status_q[best_q] <= ST_RUNNING;
						quant_q[best_q] <= base_q[best_q];
						cur_q <= best_q;
						sw_q <= 1'b1;
					end
				end
				FSM_FETCH: ;
				FSM_READ: ;
				FSM_OUT: begin
					if (out_free) begin
						out_q[63:0] <= (cmd_q != 3'(CMD_TICK)) ? 64'd0 :
							(keep_q ? ctx_q : ram_rdata);
						out_q[67:64] <= 4'(cur_q);
						out_q[68] <= sw_q;
						out_q[72:69] <= created_q;
						out_q[73] <= full_q;
						out_q[79:74] <= '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

### src/pts_checker.sv
// Port-level checker for the priority task scheduler, bound to the top level.
`timescale 1ns / 1ps
module pts_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [79:0]  m_axis_tdata,
	input logic         pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed while stalled");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted beat");
	a_switch_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[68] |-> !m_axis_tdata[73])
		else $error("switch and full flagged together");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.pready        (pready)
);
